/* rtl/acdt_pkg.sv */
// Shared types, constants and the arctangent table for the tilt detector.
package acdt_pkg;

	localparam int AXIS_W = 10;
	localparam int ACC_FRAC = 20;
	localparam int TAB_LEN = 24;
	// root operand: sum of two squares (20 bits) shifted by 32
	localparam int SQ_W = 52;
	localparam int RT_W = 26;
	// CORDIC working width
	localparam int CW = 32;
	localparam int ZW = 28;

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_LOAD = 2'd1;
	localparam logic [1:0] CMD_ROOT = 2'd2;
	localparam logic [1:0] CMD_ROT  = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic       sel;      // 0: pitch, 1: roll
		logic       capture;  // store the finished angle
		logic       latch;    // take the new sample
	} acdt_cmd_t;

	typedef struct packed {
		logic moved;
		logic root_done;
		logic rot_done;
	} acdt_stat_t;

	function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
		case (i)
			5'd0:  atan_deg = 28'sd47185920;
			5'd1:  atan_deg = 28'sd27855475;
			5'd2:  atan_deg = 28'sd14718068;
			5'd3:  atan_deg = 28'sd7471121;
			5'd4:  atan_deg = 28'sd3750058;
			5'd5:  atan_deg = 28'sd1876857;
			5'd6:  atan_deg = 28'sd938658;
			5'd7:  atan_deg = 28'sd469357;
			5'd8:  atan_deg = 28'sd234682;
			5'd9:  atan_deg = 28'sd117342;
			5'd10: atan_deg = 28'sd58671;
			5'd11: atan_deg = 28'sd29335;
			5'd12: atan_deg = 28'sd14668;
			5'd13: atan_deg = 28'sd7334;
			5'd14: atan_deg = 28'sd3667;
			5'd15: atan_deg = 28'sd1833;
			5'd16: atan_deg = 28'sd917;
			5'd17: atan_deg = 28'sd458;
			5'd18: atan_deg = 28'sd229;
			5'd19: atan_deg = 28'sd115;
			5'd20: atan_deg = 28'sd57;
			5'd21: atan_deg = 28'sd29;
			5'd22: atan_deg = 28'sd14;
			5'd23: atan_deg = 28'sd7;
			default: atan_deg = '0;
		endcase
	endfunction

endpackage

/* rtl/acdt_ctrl.sv */
// Sequencer for the tilt detector: accept, compare, root, rotate, report.
module acdt_ctrl import acdt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic       out_busy,
	input  acdt_stat_t stat,
	output logic       ready,
	output logic       out_load,
	output acdt_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CMP  = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_ROOT = 3'd3;
	localparam logic [2:0] S_ROT  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       sel_q, sel_d;

	assign ready = (state_q == S_IDLE);

	// next state and command
	always_comb begin
		state_d = state_q;
		sel_d = sel_q;
		cmd = '0;
		cmd.sel = sel_q;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) state_d = S_CMP;
			end
			S_CMP: begin
				sel_d = 1'b0;
				if (stat.moved) begin
					cmd.latch = 1'b1;
					state_d = S_LOAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LOAD: begin
				cmd.op = CMD_LOAD;
				state_d = S_ROOT;
			end
			S_ROOT: begin
				cmd.op = CMD_ROOT;
				if (stat.root_done) state_d = S_ROT;
			end
			S_ROT: begin
				cmd.op = CMD_ROT;
				if (stat.rot_done) begin
					cmd.capture = 1'b1;
					if (sel_q) begin
						state_d = S_OUT;
					end else begin
						sel_d = 1'b1;
						state_d = S_LOAD;
					end
				end
			end
			S_OUT: begin
				if (!out_busy) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q <= sel_d;
		end
	end

endmodule

/* rtl/acdt_dp.sv */
// Datapath: sample registers, change compare, bit-serial root and CORDIC.
module acdt_dp import acdt_pkg::*; #(
	parameter int ANGLE_FRACTION_BITS = 8,
	parameter int ANGLE_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_fire,
	input  logic [47:0] in_data,
	input  logic [9:0]  thr,
	input  acdt_cmd_t   cmd,
	output acdt_stat_t  stat,
	output logic signed [9:0]  ax,
	output logic signed [9:0]  ay,
	output logic signed [9:0]  az,
	output logic signed [15:0] pitch,
	output logic signed [15:0] roll
);

	localparam int STEPS = (ANGLE_STEPS > TAB_LEN) ? TAB_LEN : ANGLE_STEPS;
	localparam int SHIFT = ACC_FRAC - ANGLE_FRACTION_BITS;
	localparam int LIM = 90 << ANGLE_FRACTION_BITS;
	localparam logic signed [ZW-1:0] LIM_Z = ZW'(LIM);
	localparam logic signed [ZW-1:0] RND = ZW'(1) <<< (SHIFT - 1);
	localparam logic signed [ZW-1:0] ANG_MAX = ZW'(32767);
	localparam logic signed [ZW-1:0] ANG_MIN = ZW'(-32768);

	logic signed [9:0] sx_q, sy_q, sz_q, rx_q, ry_q, rz_q;
	logic signed [10:0] dx, dy, dz;
	logic [10:0] mx, my, mz;
	logic moved_w, root_done_w, rot_done_w;

	// form the axes at acceptance
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sx_q <= {in_data[9:8], in_data[7:0]};
			sy_q <= {in_data[25:24], in_data[23:16]};
			sz_q <= {in_data[41:40], in_data[39:32]};
		end
	end

	// compare with the reference
	assign dx = {sx_q[9], sx_q} - {rx_q[9], rx_q};
	assign dy = {sy_q[9], sy_q} - {ry_q[9], ry_q};
	assign dz = {sz_q[9], sz_q} - {rz_q[9], rz_q};
	assign mx = dx[10] ? 11'(-dx) : 11'(dx);
	assign my = dy[10] ? 11'(-dy) : 11'(dy);
	assign mz = dz[10] ? 11'(-dz) : 11'(dz);
	assign moved_w = (mx >= {1'b0, thr}) || (my >= {1'b0, thr}) || (mz >= {1'b0, thr});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q <= '0;
			ry_q <= '0;
			rz_q <= '0;
		end else if (cmd.latch) begin
			rx_q <= sx_q;
			ry_q <= sy_q;
			rz_q <= sz_q;
		end
	end

	// operands of the current angle
	logic signed [9:0] na, nb;
	assign na = cmd.sel ? sy_q : sx_q;
	assign nb = cmd.sel ? sx_q : sy_q;

	// sum of squares, up to 2^19
	logic signed [19:0] nb_w, nz_w;
	logic [19:0] ssum;
	assign nb_w = 20'(nb);
	assign nz_w = 20'(sz_q);
	assign ssum = 20'(nb_w * nb_w + nz_w * nz_w);

	// bit-serial root, two operand bits a cycle
	logic [SQ_W-1:0] rem_q, opnd_q;
	logic [RT_W-1:0] root_q, root_next;
	logic [4:0] rcnt_q;
	logic [RT_W+1:0] trial;
	logic [RT_W+1:0] rem_top;
	logic root_bit;
	assign rem_top = {rem_q[RT_W-1:0], opnd_q[SQ_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign root_bit = (rem_top >= trial);
	assign root_next = {root_q[RT_W-2:0], root_bit};
	assign root_done_w = (rcnt_q == 5'(RT_W - 1));

	// CORDIC state
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic [4:0] i_q;
	logic       zero_q;
	assign rot_done_w = (i_q == 5'(STEPS - 1));

	assign stat = '{moved: moved_w, root_done: root_done_w, rot_done: rot_done_w};

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_LOAD: begin
				opnd_q <= {ssum, 32'd0};
				rem_q <= '0;
				root_q <= '0;
				rcnt_q <= '0;
				i_q <= '0;
				cz_q <= '0;
				zero_q <= (na == 10'sd0);
				cy_q <= CW'(na) <<< 16;
			end
			CMD_ROOT: begin
				opnd_q <= opnd_q << 2;
				rcnt_q <= rcnt_q + 5'd1;
				root_q <= root_next;
				if (root_bit) rem_q <= SQ_W'(rem_top - trial);
				else rem_q <= SQ_W'(rem_top);
				// the finished root is the rotation start value
				if (root_done_w) cx_q <= CW'(root_next);
			end
			CMD_ROT: begin
				i_q <= i_q + 5'd1;
				if (cy_q > 0) begin
					cx_q <= cx_q + (cy_q >>> i_q);
					cy_q <= cy_q - (cx_q >>> i_q);
					cz_q <= cz_q + atan_deg(i_q);
				end else begin
					cx_q <= cx_q - (cy_q >>> i_q);
					cy_q <= cy_q + (cx_q >>> i_q);
					cz_q <= cz_q - atan_deg(i_q);
				end
			end
			default: ;
		endcase
	end

	// final angle of the step that just ended
	logic signed [ZW-1:0] zfin, zr, zs;
	assign zfin = (cy_q > 0) ? cz_q + atan_deg(i_q) : cz_q - atan_deg(i_q);
	assign zr = (zfin + RND) >>> SHIFT;

	// clamp to +-90 degrees, then to the output range
	logic signed [15:0] ang;
	always_comb begin
		if (zr > LIM_Z) zs = LIM_Z;
		else if (zr < -LIM_Z) zs = -LIM_Z;
		else zs = zr;
		if (zero_q) ang = '0;
		else if (zs > ANG_MAX) ang = 16'(ANG_MAX);
		else if (zs < ANG_MIN) ang = 16'(ANG_MIN);
		else ang = 16'(zs);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			if (cmd.sel) roll <= ang;
			else pitch <= ang;
		end
	end

	assign ax = sx_q;
	assign ay = sy_q;
	assign az = sz_q;

endmodule

/* rtl/accel_change_detect_tilt.sv */
// Top level of the accelerometer change detector with tilt angles.
// Each accepted word is one raw six-byte sample. It is compared against the last reported
// sample in the compare state; without a change at or above change_threshold on any axis
// the word is dropped and the block goes back to idle, ready again. With a change, pitch
// and roll are each computed by a 26-bit bit-serial square root followed by ANGLE_STEPS
// (at most 24) CORDIC vectoring steps on a single shared unit; no new word is taken until
// the report is loaded. The result sits in an output register until taken.
module accel_change_detect_tilt import acdt_pkg::*; #(
	parameter int ANGLE_FRACTION_BITS = 8,
	parameter int ANGLE_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// x_low, x_high, y_low, y_high, z_low, z_high
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// accel_x, accel_y, accel_z, pitch_angle, roll_angle, 2 zero bits
	output logic [63:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [9:0] thr_q;
	acdt_cmd_t cmd;
	acdt_stat_t stat;
	logic in_fire, out_load;
	logic signed [9:0] ax, ay, az;
	logic signed [15:0] pitch, roll;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {22'd0, thr_q} : 32'd0;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= 10'd2;
		else if (psel && penable && pwrite && paddr == 2'd0) thr_q <= pwdata[9:0];
	end

	assign in_fire = s_tvalid && s_tready;

	acdt_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_busy(m_tvalid && !m_tready), .stat,
		.ready(s_tready), .out_load, .cmd
	);

	acdt_dp #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .ANGLE_STEPS(ANGLE_STEPS)) u_dp (
		.clk, .arst_n, .in_fire, .in_data(s_tdata), .thr(thr_q), .cmd, .stat,
		.ax, .ay, .az, .pitch, .roll
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (out_load) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) m_tdata <= {2'b00, roll, pitch, az, ay, ax};
	end

endmodule

/* tb/accel_change_detect_tilt_test.sv */
// Testbench for the accelerometer change detector: stream stimulus, APB setup, scoreboard.
module accel_change_detect_tilt_test;
	import acdt_pkg::*;

	typedef struct {
		logic signed [9:0]  ax;
		logic signed [9:0]  ay;
		logic signed [9:0]  az;
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
	} report_t;

	localparam int FRAC_BITS = 8;
	localparam int CORDIC_STEPS = 16;
	localparam logic [1:0] ADDR_THRESHOLD = 2'd0;

	// atan(2^-i) in degrees, 20 fraction bits
	localparam longint ATAN_STEP [24] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// x_low, x_high, y_low, y_high, z_low, z_high
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// accel_x, accel_y, accel_z, pitch_angle, roll_angle, 2 zero bits
	logic [63:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	report_t      pending_reports[$];
	logic [9:0]   threshold;
	logic signed [9:0] last_x, last_y, last_z;
	int           errors;
	int           words_sent;
	int           reports_seen;
	int           stall_cycles;
	bit           steady;

	accel_change_detect_tilt u_dut (.*);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// integer square root of a 64-bit value
	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned res, bit_val;
		res = 0;
		bit_val = 64'd1 << 62;
		while (bit_val > v)
			bit_val >>= 2;
		while (bit_val != 0) begin
			if (v >= res + bit_val) begin
				v -= res + bit_val;
				res = (res >> 1) + bit_val;
			end else begin
				res >>= 1;
			end
			bit_val >>= 2;
		end
		return res;
	endfunction

	// atan2(a, sqrt(b^2 + c^2)) in degrees by CORDIC vectoring
	function automatic logic signed [15:0] tilt_of(input int a, input int b, input int c);
		longint cx, cy, acc, dx, dy, lim;
		if (a == 0)
			return '0;
		cx = longint'(root64(longint'(b * b + c * c) << 32));
		cy = longint'(a) * 65536;
		acc = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy > 0) begin
				cx += dx;
				cy -= dy;
				acc += ATAN_STEP[i];
			end else begin
				cx -= dx;
				cy += dy;
				acc -= ATAN_STEP[i];
			end
		end
		acc = (acc + (longint'(1) << (ACC_FRAC - FRAC_BITS - 1))) >>> (ACC_FRAC - FRAC_BITS);
		lim = longint'(90) << FRAC_BITS;
		if (acc > lim)
			acc = lim;
		if (acc < -lim)
			acc = -lim;
		return acc[15:0];
	endfunction

	function automatic bit axis_moved(input int now, input int ref_v);
		int d;
		d = now - ref_v;
		if (d < 0)
			d = -d;
		return d >= int'(threshold);
	endfunction

	// predict the report, if any, of one accepted word
	task automatic predict_report(input logic [47:0] w);
		logic signed [9:0] x, y, z;
		report_t r;
		x = {w[9:8], w[7:0]};
		y = {w[25:24], w[23:16]};
		z = {w[41:40], w[39:32]};
		if (!(axis_moved(x, last_x) || axis_moved(y, last_y) || axis_moved(z, last_z)))
			return;
		last_x = x;
		last_y = y;
		last_z = z;
		r.ax = x;
		r.ay = y;
		r.az = z;
		r.pitch = tilt_of(x, y, z);
		r.roll = tilt_of(y, x, z);
		pending_reports.push_back(r);
	endtask

	// pack three axes, with junk in the unused high-byte bits
	function automatic logic [47:0] sample_word(input int x, input int y, input int z,
			input logic [5:0] junk);
		logic [9:0] vx, vy, vz;
		vx = 10'(x);
		vy = 10'(y);
		vz = 10'(z);
		return {junk, vz[9:8], vz[7:0], junk, vy[9:8], vy[7:0], junk, vx[9:8], vx[7:0]};
	endfunction

	// offer one word, idling at random first, and predict it once taken
	task automatic send_word(input logic [47:0] w);
		while (!steady && $urandom_range(99) < 32) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do
			@(posedge clk);
		while (!s_tready);
		predict_report(w);
		words_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// write the threshold and read it back
	task automatic set_threshold(input logic [9:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_THRESHOLD;
		pwdata <= {22'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		threshold = v;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[9:0] !== v)
			$error("threshold readback: expected %0d actual %0d", v, prdata[9:0]);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int rand_axis();
		return int'($urandom_range(1023)) - 512;
	endfunction

	// step near the reference so both reports and drops happen
	function automatic int near(input int base, input int span);
		int v;
		v = base + int'($urandom_range(2 * span)) - span;
		if (v > 511)
			v = 511;
		if (v < -512)
			v = -512;
		return v;
	endfunction

	task automatic test_directed();
		send_word(sample_word(0, 0, 0, 6'h00));          // no change from reset reference
		send_word(sample_word(1, 0, 0, 6'h00));          // below default threshold
		send_word(sample_word(2, 0, 0, 6'h00));          // exactly at threshold
		send_word(sample_word(511, 0, 0, 6'h3F));        // zero root, positive
		send_word(sample_word(-512, 0, 0, 6'h15));       // zero root, negative
		send_word(sample_word(0, 511, 0, 6'h2A));        // zero numerator for pitch
		send_word(sample_word(0, 0, 511, 6'h3F));
		send_word(sample_word(0, 0, -512, 6'h00));
		send_word(sample_word(511, 511, 511, 6'h3F));
		send_word(sample_word(-512, -512, -512, 6'h3F));
		send_word(sample_word(-512, 511, -1, 6'h01));
		send_word(sample_word(1, -1, 1, 6'h20));
		send_word(sample_word(300, -200, 100, 6'h3F));
		send_word(sample_word(301, -200, 100, 6'h3F));   // one count, dropped
		send_word(sample_word(300, -198, 100, 6'h00));   // y at threshold
		send_word(sample_word(-1, -1, -1, 6'h00));
		wait_idle();
	endtask

	task automatic test_threshold_extremes();
		set_threshold(10'd0);
		for (int i = 0; i < 10; i++)
			send_word(sample_word(near(last_x, 1), last_y, last_z, 6'($urandom)));
		wait_idle();
		set_threshold(10'd1023);
		send_word(sample_word(-512, 0, 0, 6'h00));
		send_word(sample_word(511, 0, 0, 6'h00));
		send_word(sample_word(-512, 511, -512, 6'h3F));
		send_word(sample_word(511, -512, 511, 6'h3F));
		wait_idle();
	endtask

	task automatic random_phase(input int count, input int span);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0)
				send_word(48'({$urandom, $urandom}));
			else
				send_word(sample_word(near(last_x, span), near(last_y, span),
					near(last_z, span), 6'($urandom)));
		end
	endtask

	task automatic test_random();
		set_threshold(10'd2);
		random_phase(400, 3);
		wait_idle();
		set_threshold(10'($urandom_range(5, 40)));
		random_phase(400, 40);
		wait_idle();
		set_threshold(10'($urandom_range(100, 600)));
		random_phase(350, 500);
		wait_idle();
		set_threshold(10'd0);
		steady = 1'b1;
		random_phase(250, 512);
		steady = 1'b0;
		wait_idle();
	endtask

	// receiver holds off while words keep coming, then sender drains
	task automatic test_backpressure();
		set_threshold(10'd1);
		stall_cycles = 600;
		steady = 1'b1;
		for (int i = 0; i < 20; i++)
			send_word(sample_word(rand_axis(), rand_axis(), rand_axis(), 6'($urandom)));
		steady = 1'b0;
		wait_idle();
		random_phase(200, 20);
		wait_idle();
	endtask

	// receiver: random ready, compare each word with the oldest prediction
	always @(posedge clk) begin
		report_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected report %h", m_tdata);
				errors++;
			end else begin
				e = pending_reports.pop_front();
				reports_seen++;
				if (m_tdata[9:0] !== e.ax) begin
					$error("accel_x: expected %0d actual %0d", e.ax, $signed(m_tdata[9:0]));
					errors++;
				end
				if (m_tdata[19:10] !== e.ay) begin
					$error("accel_y: expected %0d actual %0d", e.ay, $signed(m_tdata[19:10]));
					errors++;
				end
				if (m_tdata[29:20] !== e.az) begin
					$error("accel_z: expected %0d actual %0d", e.az, $signed(m_tdata[29:20]));
					errors++;
				end
				if (m_tdata[45:30] !== e.pitch) begin
					$error("pitch_angle: expected %0d actual %0d", e.pitch,
						$signed(m_tdata[45:30]));
					errors++;
				end
				if (m_tdata[61:46] !== e.roll) begin
					$error("roll_angle: expected %0d actual %0d", e.roll,
						$signed(m_tdata[61:46]));
					errors++;
				end
				if (m_tdata[63:62] !== 2'b00) begin
					$error("pad bits: expected 0 actual %0d", m_tdata[63:62]);
					errors++;
				end
			end
		end
		if (stall_cycles > 0) begin
			stall_cycles <= stall_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 32);
		end
	end

	initial begin
		#30_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		threshold = 10'd2;
		last_x = 0;
		last_y = 0;
		last_z = 0;
		errors = 0;
		words_sent = 0;
		reports_seen = 0;
		stall_cycles = 0;
		steady = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold_extremes();
		test_random();
		test_backpressure();
		wait_idle();
		$display("covered %0d sample words and %0d reports over thresholds 0..1023,",
			words_sent, reports_seen);
		$display("with random idling, a long output stall and drained pauses");
		if (errors == 0 && pending_reports.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
rtl/acdt_pkg.sv
rtl/acdt_ctrl.sv
rtl/acdt_dp.sv
rtl/accel_change_detect_tilt.sv
tb/accel_change_detect_tilt_test.sv
